FILE: design/kscnt_pkg.sv
// ----------------------------------------------------------------------------
// kscnt_pkg: shared types and constants for the keyed saturating count table
// Slot geometry, slot word layout, operation codes, sequencer states and the
// scan result bundle.
// ----------------------------------------------------------------------------
package kscnt_pkg;

  localparam int unsigned SLOT_COUNT = 40;
  localparam int unsigned IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int unsigned KEY_W  = 16;
  localparam int unsigned TYPE_W = 12;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned WORD_W = KEY_W + CNT_W;  // count in 23:16, key in 15:0
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned DELTA_W = 9;
  localparam int unsigned SUM_W  = 11;             // holds -256 .. 510

  localparam logic [CNT_W-1:0] CAP_RESET = 8'd99;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_FIND  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_FINISH = 2'd3
  } state_e;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic             empty_found;
    logic [IDX_W-1:0] empty_idx;
  } scan_res_t;

endpackage

FILE: design/keyed_saturating_count_table.sv
// ----------------------------------------------------------------------------
// keyed_saturating_count_table: keyed slot table with saturating counts
// Add / query / find-type over a table of key+count slots held in one RAM.
// ----------------------------------------------------------------------------
// Flow: from input transfer to out_valid_o the item passes the scan
//   (one RAM read per slot), a drain step for the last read and an update step.
// A new item is taken only in the idle state, after the previous result is
//   registered; a stalled result holds the block in the update step.
// Reset: slot valid bits cleared so every slot reads empty, count_cap back
//   to 99, no result pending. RAM contents are not cleared.
module keyed_saturating_count_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel (count_cap)
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kscnt_pkg::CNT_W-1:0]         cfg_data_i,
  // input item channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          op_i,
  input  logic [kscnt_pkg::KEY_W-1:0]         key_i,
  input  logic signed [kscnt_pkg::DELTA_W-1:0] delta_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [kscnt_pkg::SLOT_W-1:0]        slot_o,
  output logic [kscnt_pkg::CNT_W-1:0]         count_o
);

  localparam logic [kscnt_pkg::IDX_W-1:0] LastIdx =
    kscnt_pkg::IDX_W'(kscnt_pkg::SLOT_COUNT - 1);

  // --------------------------------------------------------------------------
  // Configuration: count_cap is always writable; the block is idle by contract.
  // --------------------------------------------------------------------------
  logic [kscnt_pkg::CNT_W-1:0] cap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= kscnt_pkg::CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and item registers
  // --------------------------------------------------------------------------
  kscnt_pkg::state_e state_q, state_d;

  logic                                 in_xfer;
  logic                                 out_free;
  logic                                 finish;
  kscnt_pkg::op_e                       op_q;
  logic [kscnt_pkg::KEY_W-1:0]          key_q;
  logic signed [kscnt_pkg::DELTA_W-1:0] delta_q;
  logic [kscnt_pkg::IDX_W-1:0]          idx_q, idx_d;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;
  assign finish   = (state_q == kscnt_pkg::ST_FINISH) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kscnt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = kscnt_pkg::ST_SCAN;
      end
      kscnt_pkg::ST_SCAN: begin
        if (idx_q == LastIdx) state_d = kscnt_pkg::ST_DRAIN;
      end
      kscnt_pkg::ST_DRAIN: begin
        state_d = kscnt_pkg::ST_FINISH;
      end
      kscnt_pkg::ST_FINISH: begin
        if (out_free) state_d = kscnt_pkg::ST_IDLE;
      end
      default: begin
        state_d = kscnt_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  logic rd_en;
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    idx_d      = idx_q;
    case (state_q)
      kscnt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        idx_d      = '0;
      end
      kscnt_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        idx_d = idx_q + 1'b1;
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kscnt_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // item payload, captured on the input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= kscnt_pkg::op_e'(op_i);
      key_q   <= key_i;
      delta_q <= delta_i;
    end
  end

  // --------------------------------------------------------------------------
  // Slot storage. Valid bits make a never-written slot read as zero (empty).
  // --------------------------------------------------------------------------
  logic [kscnt_pkg::SLOT_COUNT-1:0] vld_q;
  logic                             rd_vld_q;
  logic [kscnt_pkg::IDX_W-1:0]      rd_idx_q;
  logic                             ent_vld_q;
  logic [kscnt_pkg::WORD_W-1:0]     ram_rdata;
  logic [kscnt_pkg::WORD_W-1:0]     slot_word;

  logic                             wr_en;
  logic [kscnt_pkg::IDX_W-1:0]      wr_idx;
  logic [kscnt_pkg::WORD_W-1:0]     wr_word;

  kscnt_ram #(
    .WIDTH (kscnt_pkg::WORD_W),
    .DEPTH (kscnt_pkg::SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (wr_word),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (wr_en) vld_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_idx_q  <= idx_q;
      ent_vld_q <= vld_q[idx_q];
    end
  end

  assign slot_word = ent_vld_q ? ram_rdata : '0;

  // --------------------------------------------------------------------------
  // Scan: first match (full key, or type for find-type) and first empty slot
  // --------------------------------------------------------------------------
  kscnt_pkg::scan_res_t scan_res;

  kscnt_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (in_xfer),
    .word_vld_i (rd_vld_q),
    .word_idx_i (rd_idx_q),
    .word_i     (slot_word),
    .op_i       (op_q),
    .key_i      (key_q),
    .res_o      (scan_res)
  );

  // --------------------------------------------------------------------------
  // Update: saturating add, slot clear, new-slot creation, result select
  // --------------------------------------------------------------------------
  logic signed [kscnt_pkg::SUM_W-1:0] sum;
  logic signed [kscnt_pkg::SUM_W-1:0] sat;
  logic signed [kscnt_pkg::SUM_W-1:0] cap_s;
  logic                               clr;
  logic                               delta_pos;
  logic [kscnt_pkg::CNT_W-1:0]        new_cnt;

  logic                               res_hit;
  logic [kscnt_pkg::IDX_W-1:0]        res_idx;
  logic [kscnt_pkg::CNT_W-1:0]        res_cnt;
  logic                               upd_we;

  always_comb begin
    cap_s = $signed({{(kscnt_pkg::SUM_W - kscnt_pkg::CNT_W){1'b0}}, cap_q});
    sum   = $signed({{(kscnt_pkg::SUM_W - kscnt_pkg::CNT_W){1'b0}}, scan_res.cnt})
          + kscnt_pkg::SUM_W'(delta_q);
    sat   = (sum > cap_s) ? cap_s : sum;
    clr   = sat[kscnt_pkg::SUM_W-1] || (sat == '0);

    delta_pos = !delta_q[kscnt_pkg::DELTA_W-1] && (delta_q != '0);
    if (!delta_pos) begin
      new_cnt = '0;
    end else if (delta_q[kscnt_pkg::CNT_W-1:0] > cap_q) begin
      new_cnt = cap_q;
    end else begin
      new_cnt = delta_q[kscnt_pkg::CNT_W-1:0];
    end

    res_hit = 1'b0;
    res_idx = '0;
    res_cnt = '0;
    upd_we  = 1'b0;
    wr_idx  = scan_res.idx;
    wr_word = '0;

    case (op_q)
      kscnt_pkg::OP_ADD: begin
        if (key_q == '0) begin
          res_hit = 1'b0;
        end else if (scan_res.found) begin
          // existing key: saturating add, clear on zero or below
          upd_we  = 1'b1;
          res_hit = 1'b1;
          res_idx = scan_res.idx;
          res_cnt = clr ? '0 : sat[kscnt_pkg::CNT_W-1:0];
          wr_word = clr ? '0 : {sat[kscnt_pkg::CNT_W-1:0], key_q};
        end else if ((new_cnt != '0) && scan_res.empty_found) begin
          // new key takes the first empty slot
          upd_we  = 1'b1;
          res_hit = 1'b1;
          res_idx = scan_res.empty_idx;
          res_cnt = new_cnt;
          wr_idx  = scan_res.empty_idx;
          wr_word = {new_cnt, key_q};
        end
      end
      kscnt_pkg::OP_QUERY: begin
        if ((key_q[kscnt_pkg::TYPE_W-1:0] != '0) && scan_res.found) begin
          res_hit = 1'b1;
          res_idx = scan_res.idx;
          res_cnt = scan_res.cnt;
        end
      end
      kscnt_pkg::OP_FIND: begin
        if (scan_res.found) begin
          res_hit = 1'b1;
          res_idx = scan_res.idx;
          res_cnt = scan_res.cnt;
        end
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase

    wr_en = finish && upd_we;
  end

  // --------------------------------------------------------------------------
  // Output register: holds a result until the transfer completes
  // --------------------------------------------------------------------------
  logic                        out_valid_q, out_valid_d;
  logic                        hit_q;
  logic [kscnt_pkg::SLOT_W-1:0] slot_q;
  logic [kscnt_pkg::CNT_W-1:0]  cnt_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      hit_q  <= res_hit;
      slot_q <= kscnt_pkg::SLOT_W'(res_idx);
      cnt_q  <= res_cnt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign slot_o      = slot_q;
  assign count_o     = cnt_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == kscnt_pkg::ST_SCAN) && (idx_q == '0))
    else $error("input transfer did not start a scan at slot 0");

  a_write_only_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == kscnt_pkg::ST_FINISH) && out_free)
    else $error("slot write outside the finish step");

  a_read_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ($past(state_q) == kscnt_pkg::ST_SCAN))
    else $error("slot word compared without a scan read");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (slot_o == '0) && (count_o == '0))
    else $error("miss result carries a slot or count");

  a_finish_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o)
    else $error("finished item did not produce a result");

endmodule

FILE: design/kscnt_ram.sv
// ----------------------------------------------------------------------------
// kscnt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kscnt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/kscnt_scan.sv
// ----------------------------------------------------------------------------
// kscnt_scan: slot compare and first-match capture
// Compares each slot word as it streams out of the RAM and keeps the first
// matching slot and the first empty slot.
// ----------------------------------------------------------------------------
module kscnt_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic                         word_vld_i,
  input  logic [kscnt_pkg::IDX_W-1:0]  word_idx_i,
  input  logic [kscnt_pkg::WORD_W-1:0] word_i,
  input  kscnt_pkg::op_e               op_i,
  input  logic [kscnt_pkg::KEY_W-1:0]  key_i,
  output kscnt_pkg::scan_res_t         res_o
);

  kscnt_pkg::scan_res_t res_q, res_d;
  logic                 is_match;
  logic                 is_empty;

  always_comb begin
    // find-type compares the type bits only
    if (op_i == kscnt_pkg::OP_FIND) begin
      is_match = (word_i[kscnt_pkg::TYPE_W-1:0] == key_i[kscnt_pkg::TYPE_W-1:0]);
    end else begin
      is_match = (word_i[kscnt_pkg::KEY_W-1:0] == key_i);
    end
    is_empty = (word_i[kscnt_pkg::KEY_W-1:0] == '0);
  end

  always_comb begin
    res_d = res_q;
    if (clear_i) begin
      res_d = '0;
    end else if (word_vld_i) begin
      if (is_match && !res_q.found) begin
        res_d.found = 1'b1;
        res_d.idx   = word_idx_i;
        res_d.cnt   = word_i[kscnt_pkg::WORD_W-1:kscnt_pkg::KEY_W];
      end
      if (is_empty && !res_q.empty_found) begin
        res_d.empty_found = 1'b1;
        res_d.empty_idx   = word_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
